### src/m4ta_pkg.sv
// Shared types, constants and micro-op decode for the 4x4 matrix engine.
// No dependencies; used by m4ta_ctrl, m4ta_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package m4ta_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic signed [31:0] FIX_ONE = 32'sd1 <<< FRAC_BITS;

	// command codes
	localparam logic [3:0] MODE_IDENT  = 4'd0;
	localparam logic [3:0] MODE_FILL   = 4'd1;
	localparam logic [3:0] MODE_DIAG   = 4'd2;
	localparam logic [3:0] MODE_WRCOL  = 4'd3;
	localparam logic [3:0] MODE_WRROW  = 4'd4;
	localparam logic [3:0] MODE_SCALE  = 4'd5;
	localparam logic [3:0] MODE_TRANSP = 4'd6;
	localparam logic [3:0] MODE_LDB    = 4'd7;
	localparam logic [3:0] MODE_MUL    = 4'd8;
	localparam logic [3:0] MODE_TRANSL = 4'd9;
	localparam logic [3:0] MODE_SCALE3 = 4'd10;
	localparam logic [3:0] MODE_DET    = 4'd11;
	localparam logic [3:0] MODE_RDCOL  = 4'd12;
	localparam logic [3:0] MODE_COPYB  = 4'd13;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_SAT   = 2'd2;

	typedef struct packed {
		logic [3:0]         mode;
		logic [2:0]         index;
		logic signed [31:0] arg0;
		logic signed [31:0] arg1;
		logic signed [31:0] arg2;
		logic signed [31:0] arg3;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value0;
		logic signed [31:0] value1;
		logic signed [31:0] value2;
		logic signed [31:0] value3;
		logic [1:0]         status;
	} rsp_t;

	// multiplier B operand source
	typedef enum logic [2:0] {
		BSRC_OPB, BSRC_CUR, BSRC_SCR, BSRC_ARG, BSRC_ONE
	} bsrc_t;

	// destination of a finished sum
	typedef enum logic [1:0] {
		DST_CUR, DST_TMP, DST_SCR, DST_VAL
	} dst_t;

	// one multiply-accumulate step; A always comes from the current matrix
	typedef struct packed {
		logic [3:0] a_idx;
		bsrc_t      b_src;
		logic [3:0] b_idx;
		logic       neg;
		logic       first;
		logic       last;
		dst_t       dst;
		logic [3:0] dst_idx;
	} uop_t;

	typedef enum logic [2:0] {
		CMD_NONE, CMD_LOAD, CMD_DIRECT, CMD_FETCH,
		CMD_MULT, CMD_ACCUM, CMD_COMMIT, CMD_RESULT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		uop_t      uop;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_status_t;

	function automatic logic is_mac(input logic [3:0] mode);
		case (mode) inside
			MODE_SCALE, MODE_SCALE3, MODE_TRANSL, MODE_MUL, MODE_DET: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// index of the final step of a multiply-accumulate command
	function automatic logic [5:0] last_step(input logic [3:0] mode);
		case (mode)
			MODE_SCALE:  return 6'd15;
			MODE_SCALE3: return 6'd11;
			MODE_TRANSL: return 6'd15;
			MODE_MUL:    return 6'd63;
			MODE_DET:    return 6'd27;
			default:     return 6'd0;
		endcase
	endfunction

	// clamp to 32 bits; bit 32 flags a clamp
	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF)
			return {1'b1, 32'h7FFF_FFFF};
		else if (v < -64'sh8000_0000)
			return {1'b1, 32'h8000_0000};
		else
			return {1'b0, v[31:0]};
	endfunction

	function automatic uop_t mk(input logic [3:0] a, input bsrc_t bs, input logic [3:0] b,
		input logic ng, input logic fs, input logic ls, input dst_t d, input logic [3:0] di);
		uop_t u;
		u.a_idx = a; u.b_src = bs; u.b_idx = b; u.neg = ng;
		u.first = fs; u.last = ls; u.dst = d; u.dst_idx = di;
		return u;
	endfunction

	// cofactor expansion: six 2x2 minors to scratch 0..5, four cofactors
	// to scratch 6..9, then the signed sum along row 0
	function automatic uop_t det_uop(input logic [4:0] s);
		case (s)
			5'd0:  return mk(4'd10, BSRC_CUR, 4'd15, 1'b0, 1'b1, 1'b0, DST_SCR, 4'd0);
			5'd1:  return mk(4'd14, BSRC_CUR, 4'd11, 1'b1, 1'b0, 1'b1, DST_SCR, 4'd0);
			5'd2:  return mk(4'd6,  BSRC_CUR, 4'd15, 1'b0, 1'b1, 1'b0, DST_SCR, 4'd1);
			5'd3:  return mk(4'd14, BSRC_CUR, 4'd7,  1'b1, 1'b0, 1'b1, DST_SCR, 4'd1);
			5'd4:  return mk(4'd6,  BSRC_CUR, 4'd11, 1'b0, 1'b1, 1'b0, DST_SCR, 4'd2);
			5'd5:  return mk(4'd10, BSRC_CUR, 4'd7,  1'b1, 1'b0, 1'b1, DST_SCR, 4'd2);
			5'd6:  return mk(4'd2,  BSRC_CUR, 4'd15, 1'b0, 1'b1, 1'b0, DST_SCR, 4'd3);
			5'd7:  return mk(4'd14, BSRC_CUR, 4'd3,  1'b1, 1'b0, 1'b1, DST_SCR, 4'd3);
			5'd8:  return mk(4'd2,  BSRC_CUR, 4'd11, 1'b0, 1'b1, 1'b0, DST_SCR, 4'd4);
			5'd9:  return mk(4'd10, BSRC_CUR, 4'd3,  1'b1, 1'b0, 1'b1, DST_SCR, 4'd4);
			5'd10: return mk(4'd2,  BSRC_CUR, 4'd7,  1'b0, 1'b1, 1'b0, DST_SCR, 4'd5);
			5'd11: return mk(4'd6,  BSRC_CUR, 4'd3,  1'b1, 1'b0, 1'b1, DST_SCR, 4'd5);
			5'd12: return mk(4'd5,  BSRC_SCR, 4'd0,  1'b0, 1'b1, 1'b0, DST_SCR, 4'd6);
			5'd13: return mk(4'd9,  BSRC_SCR, 4'd1,  1'b1, 1'b0, 1'b0, DST_SCR, 4'd6);
			5'd14: return mk(4'd13, BSRC_SCR, 4'd2,  1'b0, 1'b0, 1'b1, DST_SCR, 4'd6);
			5'd15: return mk(4'd1,  BSRC_SCR, 4'd0,  1'b0, 1'b1, 1'b0, DST_SCR, 4'd7);
			5'd16: return mk(4'd9,  BSRC_SCR, 4'd3,  1'b1, 1'b0, 1'b0, DST_SCR, 4'd7);
			5'd17: return mk(4'd13, BSRC_SCR, 4'd4,  1'b0, 1'b0, 1'b1, DST_SCR, 4'd7);
			5'd18: return mk(4'd1,  BSRC_SCR, 4'd1,  1'b0, 1'b1, 1'b0, DST_SCR, 4'd8);
			5'd19: return mk(4'd5,  BSRC_SCR, 4'd3,  1'b1, 1'b0, 1'b0, DST_SCR, 4'd8);
			5'd20: return mk(4'd13, BSRC_SCR, 4'd5,  1'b0, 1'b0, 1'b1, DST_SCR, 4'd8);
			5'd21: return mk(4'd1,  BSRC_SCR, 4'd2,  1'b0, 1'b1, 1'b0, DST_SCR, 4'd9);
			5'd22: return mk(4'd5,  BSRC_SCR, 4'd4,  1'b1, 1'b0, 1'b0, DST_SCR, 4'd9);
			5'd23: return mk(4'd9,  BSRC_SCR, 4'd5,  1'b0, 1'b0, 1'b1, DST_SCR, 4'd9);
			5'd24: return mk(4'd0,  BSRC_SCR, 4'd6,  1'b0, 1'b1, 1'b0, DST_VAL, 4'd0);
			5'd25: return mk(4'd4,  BSRC_SCR, 4'd7,  1'b1, 1'b0, 1'b0, DST_VAL, 4'd0);
			5'd26: return mk(4'd8,  BSRC_SCR, 4'd8,  1'b0, 1'b0, 1'b0, DST_VAL, 4'd0);
			default: return mk(4'd12, BSRC_SCR, 4'd9, 1'b1, 1'b0, 1'b1, DST_VAL, 4'd0);
		endcase
	endfunction

	function automatic uop_t uop_for(input logic [3:0] mode, input logic [5:0] s);
		logic [1:0] t;
		t = s[1:0];
		case (mode)
			MODE_SCALE:
				return mk(s[3:0], BSRC_ARG, 4'd0, 1'b0, 1'b1, 1'b1, DST_CUR, s[3:0]);
			MODE_SCALE3:
				return mk(s[3:0], BSRC_ARG, {2'b00, s[3:2]}, 1'b0, 1'b1, 1'b1,
					DST_CUR, s[3:0]);
			MODE_TRANSL:
				// column 3 element times one, then the three args times columns 0..2
				if (t == 2'd0)
					return mk({2'b11, s[3:2]}, BSRC_ONE, 4'd0, 1'b0, 1'b1, 1'b0,
						DST_CUR, {2'b11, s[3:2]});
				else
					return mk({2'(t - 2'd1), s[3:2]}, BSRC_ARG, {2'b00, 2'(t - 2'd1)},
						1'b0, 1'b0, (t == 2'd3), DST_CUR, {2'b11, s[3:2]});
			MODE_MUL:
				// s = {j, i, k}
				return mk({s[1:0], s[3:2]}, BSRC_OPB, {s[5:4], s[1:0]}, 1'b0,
					(t == 2'd0), (t == 2'd3), DST_TMP, {s[5:4], s[3:2]});
			MODE_DET:
				return det_uop(s[4:0]);
			default:
				return mk(4'd0, BSRC_ONE, 4'd0, 1'b0, 1'b1, 1'b1, DST_VAL, 4'd0);
		endcase
	endfunction

endpackage
`default_nettype wire

### src/m4ta_ctrl.sv
// Command sequencer for the matrix engine: accepts requests and steps the
// datapath through its direct commands or multiply-accumulate micro-ops. Depends on m4ta_pkg.
`timescale 1ns / 1ps
`default_nettype none
module m4ta_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire logic [3:0]             req_mode,
	output m4ta_pkg::ctl_cmd_t          cmd,
	input  wire m4ta_pkg::dp_status_t   dp_status
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DIRECT = 7'b0000010,
		S_FETCH  = 7'b0000100,
		S_MULT   = 7'b0001000,
		S_ACCUM  = 7'b0010000,
		S_COMMIT = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t     state_q;
	logic [3:0] mode_q;
	logic [5:0] step_q;
	logic       accept;
	logic       at_last;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign at_last   = (step_q == m4ta_pkg::last_step(mode_q));

	// command to the datapath
	always_comb begin
		cmd.uop = m4ta_pkg::uop_for(mode_q, step_q);
		case (state_q)
			S_IDLE:   cmd.kind = req_valid ? m4ta_pkg::CMD_LOAD : m4ta_pkg::CMD_NONE;
			S_DIRECT: cmd.kind = m4ta_pkg::CMD_DIRECT;
			S_FETCH:  cmd.kind = m4ta_pkg::CMD_FETCH;
			S_MULT:   cmd.kind = m4ta_pkg::CMD_MULT;
			S_ACCUM:  cmd.kind = m4ta_pkg::CMD_ACCUM;
			S_COMMIT: cmd.kind = m4ta_pkg::CMD_COMMIT;
			S_FINISH: cmd.kind = dp_status.out_full ? m4ta_pkg::CMD_NONE
				: m4ta_pkg::CMD_RESULT;
			default:  cmd.kind = m4ta_pkg::CMD_NONE;
		endcase
	end

	// opcode latch
	always_ff @(posedge clk) begin
		if (accept)
			mode_q <= req_mode;
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						state_q <= m4ta_pkg::is_mac(req_mode) ? S_FETCH : S_DIRECT;
					end
				end
				S_DIRECT: state_q <= S_FINISH;
				S_FETCH:  state_q <= S_MULT;
				S_MULT:   state_q <= S_ACCUM;
				S_ACCUM: begin
					if (at_last)
						state_q <= (mode_q == m4ta_pkg::MODE_MUL) ? S_COMMIT : S_FINISH;
					else begin
						step_q  <= step_q + 6'd1;
						state_q <= S_FETCH;
					end
				end
				S_COMMIT: state_q <= S_FINISH;
				S_FINISH: begin
					if (!dp_status.out_full)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// temp matrix copy belongs to the multiply only
	a_commit_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT |-> mode_q == m4ta_pkg::MODE_MUL)
		else $error("commit outside multiply");
	a_commit_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT |=> state_q == S_FINISH)
		else $error("commit not followed by finish");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MULT |-> step_q <= m4ta_pkg::last_step(mode_q))
		else $error("step past end of command");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && !dp_status.out_full) |=> state_q == S_IDLE)
		else $error("finish did not retire");

endmodule
`default_nettype wire

### src/m4ta_datapath.sv
// Matrix storage, shared multiplier, accumulator and output register.
// Driven by m4ta_ctrl commands. Depends on m4ta_pkg.
`timescale 1ns / 1ps
`default_nettype none
module m4ta_datapath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire m4ta_pkg::req_t        req,
	input  wire m4ta_pkg::ctl_cmd_t    cmd,
	output m4ta_pkg::dp_status_t       dp_status,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output m4ta_pkg::rsp_t             rsp
);

	logic signed [31:0] cur_q [16];
	logic signed [31:0] opb_q [16];
	logic signed [31:0] tmp_q [16];
	logic signed [31:0] scr_q [10];
	logic signed [31:0] val_q [4];
	m4ta_pkg::req_t     req_q;
	logic               err_q;
	logic               sat_q;
	logic signed [31:0] a_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic               rsp_valid_q;
	m4ta_pkg::rsp_t     rsp_q;

	logic signed [31:0] args [4];
	logic [3:0]         rd_addr;
	logic signed [31:0] rd_data;
	logic signed [31:0] bop;
	logic signed [63:0] term;
	logic signed [63:0] sum;
	logic [32:0]        sat_res;
	logic [1:0]         col;
	logic               idx_ok;
	logic               is_dir;
	logic               is_acc;
	logic               is_wb;

	assign args[0] = req_q.arg0;
	assign args[1] = req_q.arg1;
	assign args[2] = req_q.arg2;
	assign args[3] = req_q.arg3;
	assign col     = req_q.index[1:0];
	assign idx_ok  = !req_q.index[2];
	assign is_dir  = (cmd.kind == m4ta_pkg::CMD_DIRECT);
	assign is_acc  = (cmd.kind == m4ta_pkg::CMD_ACCUM);
	assign is_wb   = is_acc && cmd.uop.last;

	// shared MAC read port on the current matrix: A in fetch, B in multiply
	assign rd_addr = (cmd.kind == m4ta_pkg::CMD_FETCH) ? cmd.uop.a_idx : cmd.uop.b_idx;
	assign rd_data = cur_q[rd_addr];

	always_comb begin
		case (cmd.uop.b_src)
			m4ta_pkg::BSRC_OPB: bop = opb_q[cmd.uop.b_idx];
			m4ta_pkg::BSRC_CUR: bop = rd_data;
			m4ta_pkg::BSRC_SCR: bop = scr_q[cmd.uop.b_idx];
			m4ta_pkg::BSRC_ARG: bop = args[cmd.uop.b_idx[1:0]];
			default:            bop = m4ta_pkg::FIX_ONE;
		endcase
	end

	// truncated product joins the running sum
	assign term    = prod_q >>> m4ta_pkg::FRAC_BITS;
	assign sum     = (cmd.uop.first ? 64'sd0 : acc_q) + (cmd.uop.neg ? -term : term);
	assign sat_res = m4ta_pkg::sat32(sum);

	// request latch, MAC pipe, scratch and per-request result
	always_ff @(posedge clk) begin
		if (cmd.kind == m4ta_pkg::CMD_LOAD) begin
			req_q <= req;
			err_q <= 1'b0;
			sat_q <= 1'b0;
			for (int i = 0; i < 4; i++)
				val_q[i] <= '0;
		end
		if (cmd.kind == m4ta_pkg::CMD_FETCH)
			a_q <= rd_data;
		if (cmd.kind == m4ta_pkg::CMD_MULT)
			prod_q <= a_q * bop;
		if (is_acc)
			acc_q <= sum;
		if (is_wb) begin
			if (sat_res[32])
				sat_q <= 1'b1;
			case (cmd.uop.dst)
				m4ta_pkg::DST_TMP: tmp_q[cmd.uop.dst_idx] <= sat_res[31:0];
				m4ta_pkg::DST_SCR: scr_q[cmd.uop.dst_idx] <= sat_res[31:0];
				m4ta_pkg::DST_VAL: val_q[0] <= sat_res[31:0];
				default: ;
			endcase
		end
		if (is_dir) begin
			case (req_q.mode) inside
				m4ta_pkg::MODE_WRCOL, m4ta_pkg::MODE_WRROW,
				m4ta_pkg::MODE_LDB, m4ta_pkg::MODE_RDCOL: begin
					if (!idx_ok)
						err_q <= 1'b1;
					else if (req_q.mode == m4ta_pkg::MODE_RDCOL) begin
						for (int i = 0; i < 4; i++)
							val_q[i] <= cur_q[{col, 2'(i)}];
					end
				end
				default: ;
			endcase
		end
	end

	// matrix state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				cur_q[i] <= '0;
				opb_q[i] <= '0;
			end
		end else begin
			if (is_wb && cmd.uop.dst == m4ta_pkg::DST_CUR)
				cur_q[cmd.uop.dst_idx] <= sat_res[31:0];
			if (cmd.kind == m4ta_pkg::CMD_COMMIT) begin
				for (int i = 0; i < 16; i++)
					cur_q[i] <= tmp_q[i];
			end
			if (is_dir) begin
				case (req_q.mode)
					m4ta_pkg::MODE_IDENT:
						for (int i = 0; i < 16; i++)
							cur_q[i] <= (i % 5 == 0) ? m4ta_pkg::FIX_ONE : 32'sd0;
					m4ta_pkg::MODE_FILL:
						for (int i = 0; i < 16; i++)
							cur_q[i] <= req_q.arg0;
					m4ta_pkg::MODE_DIAG:
						for (int i = 0; i < 16; i += 5)
							cur_q[i] <= req_q.arg0;
					m4ta_pkg::MODE_WRCOL:
						if (idx_ok)
							for (int i = 0; i < 4; i++)
								cur_q[{col, 2'(i)}] <= args[i];
					m4ta_pkg::MODE_WRROW:
						if (idx_ok)
							for (int i = 0; i < 4; i++)
								cur_q[{2'(i), col}] <= args[i];
					m4ta_pkg::MODE_LDB:
						if (idx_ok)
							for (int i = 0; i < 4; i++)
								opb_q[{col, 2'(i)}] <= args[i];
					m4ta_pkg::MODE_TRANSP:
						for (int c = 0; c < 4; c++)
							for (int r = 0; r < 4; r++)
								cur_q[c * 4 + r] <= cur_q[r * 4 + c];
					m4ta_pkg::MODE_COPYB:
						for (int i = 0; i < 16; i++)
							cur_q[i] <= opb_q[i];
					default: ;
				endcase
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (cmd.kind == m4ta_pkg::CMD_RESULT)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.kind == m4ta_pkg::CMD_RESULT) begin
			rsp_q.value0 <= val_q[0];
			rsp_q.value1 <= val_q[1];
			rsp_q.value2 <= val_q[2];
			rsp_q.value3 <= val_q[3];
			rsp_q.status <= err_q ? m4ta_pkg::STATUS_RANGE
				: (sat_q ? m4ta_pkg::STATUS_SAT : m4ta_pkg::STATUS_OK);
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign rsp                = rsp_q;
	assign dp_status.out_full = rsp_valid_q;

	// never load a new response over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.kind == m4ta_pkg::CMD_RESULT |-> !rsp_valid_q)
		else $error("response overwritten");
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.kind == m4ta_pkg::CMD_RESULT && err_q) |-> (val_q[0] == 32'sd0 && !sat_q))
		else $error("range error with data");
	a_wb_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		is_acc |-> $past(cmd.kind) == m4ta_pkg::CMD_MULT)
		else $error("accumulate without product");

endmodule
`default_nettype wire

### src/mat4_transform_accumulator.sv
// Top level of the 4x4 fixed-point matrix engine.
// Instantiates m4ta_ctrl and m4ta_datapath; depends on m4ta_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Column-major 4x4 matrix engine in signed Q16.16 with one response per
// request. Requests are taken one at a time; a finished response waits in an
// output register while the next request is accepted. Set-up, edit, copy,
// transpose and column-read requests are carried out directly. Arithmetic
// requests (scale, scale3, translate, determinant and multiply) run on one
// shared 32x32 multiplier as multiply-accumulate steps, each going through
// operand fetch, multiply and accumulate; multiply ends with the copy of the
// product into the current matrix.
module mat4_transform_accumulator (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire m4ta_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output m4ta_pkg::rsp_t       rsp
);

	m4ta_pkg::ctl_cmd_t   cmd;
	m4ta_pkg::dp_status_t dp_status;

	m4ta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_mode  (req.mode),
		.cmd       (cmd),
		.dp_status (dp_status)
	);

	m4ta_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.dp_status (dp_status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the 4x4 fixed-point matrix engine.
// Depends on m4ta_pkg and mat4_transform_accumulator; a built-in predictor
// checks every response.
`timescale 1ns / 1ps
module tb_top;

	localparam logic [3:0] MODE_SPARE_LO = 4'd14;
	localparam logic [3:0] MODE_SPARE_HI = 4'd15;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 250;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	m4ta_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	m4ta_pkg::rsp_t rsp;

	mat4_transform_accumulator dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #4 clk = ~clk;

	// predictor state
	logic signed [31:0] cur_m [16];
	logic signed [31:0] opb_m [16];
	m4ta_pkg::rsp_t rsp_expected_q [$];
	int fail_cnt = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_cnt = 0;

	// truncating fixed-point product (floor)
	function automatic longint fxmul(longint a, longint b);
		return (a * b) >>> m4ta_pkg::FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic longint minor2(int a, int d, int b, int c, inout bit sat);
		return clamp32(fxmul(cur_m[a], cur_m[d]) - fxmul(cur_m[b], cur_m[c]), sat);
	endfunction

	function automatic logic signed [31:0] determinant_of_cur(inout bit sat);
		longint k1015, k0615, k0611, k0215, k0211, k0207, c0, c1, c2, c3;
		k1015 = minor2(10, 15, 14, 11, sat);
		k0615 = minor2(6, 15, 14, 7, sat);
		k0611 = minor2(6, 11, 10, 7, sat);
		k0215 = minor2(2, 15, 14, 3, sat);
		k0211 = minor2(2, 11, 10, 3, sat);
		k0207 = minor2(2, 7, 6, 3, sat);
		c0 = clamp32(fxmul(cur_m[5], k1015) - fxmul(cur_m[9], k0615)
			+ fxmul(cur_m[13], k0611), sat);
		c1 = clamp32(fxmul(cur_m[1], k1015) - fxmul(cur_m[9], k0215)
			+ fxmul(cur_m[13], k0211), sat);
		c2 = clamp32(fxmul(cur_m[1], k0615) - fxmul(cur_m[5], k0215)
			+ fxmul(cur_m[13], k0207), sat);
		c3 = clamp32(fxmul(cur_m[1], k0611) - fxmul(cur_m[5], k0211)
			+ fxmul(cur_m[9], k0207), sat);
		return clamp32(fxmul(cur_m[0], c0) - fxmul(cur_m[4], c1)
			+ fxmul(cur_m[8], c2) - fxmul(cur_m[12], c3), sat);
	endfunction

	// apply one request to the predicted state and return its response
	function automatic m4ta_pkg::rsp_t predict_response(m4ta_pkg::req_t r);
		m4ta_pkg::rsp_t o;
		bit sat;
		logic signed [31:0] t [16];
		logic signed [31:0] a [4];
		longint s;
		int idx;
		o = '0;
		sat = 1'b0;
		a[0] = r.arg0; a[1] = r.arg1; a[2] = r.arg2; a[3] = r.arg3;
		idx = r.index;
		case (r.mode)
			m4ta_pkg::MODE_IDENT:
				for (int i = 0; i < 16; i++)
					cur_m[i] = (i % 5 == 0) ? m4ta_pkg::FIX_ONE : '0;
			m4ta_pkg::MODE_FILL:  for (int i = 0; i < 16; i++) cur_m[i] = a[0];
			m4ta_pkg::MODE_DIAG:  for (int i = 0; i < 16; i += 5) cur_m[i] = a[0];
			m4ta_pkg::MODE_WRCOL, m4ta_pkg::MODE_WRROW,
			m4ta_pkg::MODE_LDB, m4ta_pkg::MODE_RDCOL: begin
				if (idx > 3) begin
					o.status = m4ta_pkg::STATUS_RANGE;
				end else begin
					for (int i = 0; i < 4; i++) begin
						if (r.mode == m4ta_pkg::MODE_WRCOL) cur_m[idx*4+i] = a[i];
						else if (r.mode == m4ta_pkg::MODE_WRROW) cur_m[i*4+idx] = a[i];
						else if (r.mode == m4ta_pkg::MODE_LDB) opb_m[idx*4+i] = a[i];
						else t[i] = cur_m[idx*4+i];
					end
					if (r.mode == m4ta_pkg::MODE_RDCOL) begin
						o.value0 = t[0]; o.value1 = t[1]; o.value2 = t[2]; o.value3 = t[3];
					end
				end
			end
			m4ta_pkg::MODE_SCALE:
				for (int i = 0; i < 16; i++) cur_m[i] = clamp32(fxmul(cur_m[i], a[0]), sat);
			m4ta_pkg::MODE_TRANSP: begin
				for (int j = 0; j < 4; j++)
					for (int i = 0; i < 4; i++) t[j*4+i] = cur_m[i*4+j];
				cur_m = t;
			end
			m4ta_pkg::MODE_MUL: begin
				for (int j = 0; j < 4; j++)
					for (int i = 0; i < 4; i++) begin
						s = 0;
						for (int k = 0; k < 4; k++) s += fxmul(cur_m[k*4+i], opb_m[j*4+k]);
						t[j*4+i] = clamp32(s, sat);
					end
				cur_m = t;
			end
			m4ta_pkg::MODE_TRANSL: begin
				for (int i = 0; i < 4; i++) begin
					s = cur_m[12+i];
					for (int k = 0; k < 3; k++) s += fxmul(a[k], cur_m[k*4+i]);
					t[i] = clamp32(s, sat);
				end
				for (int i = 0; i < 4; i++) cur_m[12+i] = t[i];
			end
			m4ta_pkg::MODE_SCALE3:
				for (int k = 0; k < 3; k++)
					for (int i = 0; i < 4; i++)
						cur_m[k*4+i] = clamp32(fxmul(cur_m[k*4+i], a[k]), sat);
			m4ta_pkg::MODE_DET: o.value0 = determinant_of_cur(sat);
			m4ta_pkg::MODE_COPYB: cur_m = opb_m;
			default: ;
		endcase
		if (o.status == m4ta_pkg::STATUS_OK && sat) o.status = m4ta_pkg::STATUS_SAT;
		return o;
	endfunction

	// random Q16.16 value: mostly modest magnitudes, some extremes and raw words
	function automatic logic signed [31:0] rand_fix();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 3) == 0 ? 32'sh7FFF_FFFF :
				($urandom_range(0, 2) == 0 ? 32'sh8000_0000 : -32'sd1);
			2: return $signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000;
			default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	function automatic m4ta_pkg::req_t mk_req(logic [3:0] m, logic [2:0] ix,
		logic signed [31:0] a0, logic signed [31:0] a1,
		logic signed [31:0] a2, logic signed [31:0] a3);
		m4ta_pkg::req_t r;
		r.mode = m; r.index = ix; r.arg0 = a0; r.arg1 = a1; r.arg2 = a2; r.arg3 = a3;
		return r;
	endfunction

	function automatic m4ta_pkg::req_t rand_req(logic [3:0] m, logic [2:0] ix);
		return mk_req(m, ix, rand_fix(), rand_fix(), rand_fix(), rand_fix());
	endfunction

	// send one request; bursts of requests separated by random gaps
	task automatic send_req(m4ta_pkg::req_t r, bit no_gaps = 1'b0);
		int gap;
		if (!no_gaps && burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(0, 4);
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		rsp_expected_q.push_back(predict_response(r));
		// retire the request before the next payload is driven
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		wait (rsp_expected_q.size() == 0);
	endtask

	// receiver stall pattern, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_stall <= 1'b1;
		end else if (($urandom_range(0, 255) < 64) || ($urandom_range(0, 7) == 0)) begin
			rsp_stall <= ($urandom_range(0, 2) == 0);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// response checker
	always @(posedge clk) begin
		m4ta_pkg::rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_expected_q.size() == 0) begin
				$error("unexpected response %h", rsp);
				fail_cnt++;
			end else begin
				e = rsp_expected_q.pop_front();
				if (rsp.value0 !== e.value0) begin
					$error("value0 expected %h actual %h", e.value0, rsp.value0); fail_cnt++;
				end
				if (rsp.value1 !== e.value1) begin
					$error("value1 expected %h actual %h", e.value1, rsp.value1); fail_cnt++;
				end
				if (rsp.value2 !== e.value2) begin
					$error("value2 expected %h actual %h", e.value2, rsp.value2); fail_cnt++;
				end
				if (rsp.value3 !== e.value3) begin
					$error("value3 expected %h actual %h", e.value3, rsp.value3); fail_cnt++;
				end
				if (rsp.status !== e.status) begin
					$error("status expected %h actual %h", e.status, rsp.status); fail_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic read_all_columns();
		for (int c = 0; c < 4; c++) send_req(mk_req(m4ta_pkg::MODE_RDCOL, 3'(c), 0, 0, 0, 0));
	endtask

	task automatic test_setup_cmds();
		send_req(mk_req(m4ta_pkg::MODE_DET, 3'd0, 0, 0, 0, 0));
		send_req(mk_req(m4ta_pkg::MODE_IDENT, 3'd7, -1, -1, -1, -1));
		send_req(mk_req(m4ta_pkg::MODE_DET, 3'd0, 0, 0, 0, 0));
		send_req(mk_req(m4ta_pkg::MODE_FILL, 3'd0, 32'sh7FFF_FFFF, 0, 0, 0));
		send_req(mk_req(m4ta_pkg::MODE_RDCOL, 3'd3, 0, 0, 0, 0));
		send_req(mk_req(m4ta_pkg::MODE_DIAG, 3'd0, 32'sh8000_0000, 0, 0, 0));
		send_req(mk_req(m4ta_pkg::MODE_WRCOL, 3'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 0));
		send_req(mk_req(m4ta_pkg::MODE_WRROW, 3'd3, 1, 2, 3, 4));
		read_all_columns();
	endtask

	task automatic test_index_range();
		send_req(mk_req(m4ta_pkg::MODE_WRCOL, 3'd4, -1, -1, -1, -1));
		send_req(mk_req(m4ta_pkg::MODE_WRROW, 3'd7, -1, -1, -1, -1));
		send_req(mk_req(m4ta_pkg::MODE_LDB, 3'd5, -1, -1, -1, -1));
		send_req(mk_req(m4ta_pkg::MODE_RDCOL, 3'd6, 0, 0, 0, 0));
		send_req(mk_req(MODE_SPARE_LO, 3'd2, -1, -1, -1, -1));
		send_req(mk_req(MODE_SPARE_HI, 3'd7, -1, -1, -1, -1));
		read_all_columns();
	endtask

	task automatic test_arith_cmds();
		send_req(mk_req(m4ta_pkg::MODE_FILL, 3'd0, 32'sh7FFF_FFFF, 0, 0, 0));
		send_req(mk_req(m4ta_pkg::MODE_SCALE, 3'd0, 32'sh0002_0000, 0, 0, 0));
		send_req(mk_req(m4ta_pkg::MODE_SCALE3, 3'd0, 32'sh8000_0000, 32'sh0000_8000, -1, 0));
		send_req(mk_req(m4ta_pkg::MODE_TRANSL, 3'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0));
		send_req(mk_req(m4ta_pkg::MODE_TRANSP, 3'd0, 0, 0, 0, 0));
		send_req(mk_req(m4ta_pkg::MODE_DET, 3'd0, 0, 0, 0, 0));
		for (int c = 0; c < 4; c++) send_req(rand_req(m4ta_pkg::MODE_LDB, 3'(c)));
		send_req(mk_req(m4ta_pkg::MODE_MUL, 3'd0, 0, 0, 0, 0));
		send_req(mk_req(m4ta_pkg::MODE_COPYB, 3'd0, 0, 0, 0, 0));
		send_req(mk_req(m4ta_pkg::MODE_DET, 3'd0, 0, 0, 0, 0));
		read_all_columns();
	endtask

	// well-formed sequences with random content, plus raw noise
	task automatic test_random_traffic(int n_items);
		int sent;
		logic [3:0] m;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 4) == 0) begin
				send_req(mk_req(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
					rand_fix(), rand_fix(), rand_fix(), rand_fix()));
				sent++;
			end else begin
				if ($urandom_range(0, 1))
					send_req(mk_req(m4ta_pkg::MODE_IDENT, 3'($urandom), 0, 0, 0, 0));
				else
					for (int c = 0; c < 4; c++) send_req(rand_req(m4ta_pkg::MODE_WRCOL, 3'(c)));
				for (int c = 0; c < 4; c++) send_req(rand_req(m4ta_pkg::MODE_LDB, 3'(c)));
				sent += 8;
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 9))
						0: m = m4ta_pkg::MODE_MUL;
						1: m = m4ta_pkg::MODE_SCALE;
						2: m = m4ta_pkg::MODE_SCALE3;
						3: m = m4ta_pkg::MODE_TRANSL;
						4: m = m4ta_pkg::MODE_TRANSP;
						5: m = m4ta_pkg::MODE_WRROW;
						6: m = m4ta_pkg::MODE_DIAG;
						7: m = m4ta_pkg::MODE_COPYB;
						8: m = m4ta_pkg::MODE_DET;
						default: m = m4ta_pkg::MODE_WRCOL;
					endcase
					send_req(rand_req(m, 3'($urandom_range(0, 4))));
					sent++;
				end
				if ($urandom_range(0, 1))
					send_req(mk_req(m4ta_pkg::MODE_DET, 3'($urandom), 0, 0, 0, 0));
				else read_all_columns();
				sent += 2;
			end
		end
	endtask

	task automatic test_backpressure();
		hold_asked++;
		for (int i = 0; i < 20; i++)
			send_req(rand_req(m4ta_pkg::MODE_RDCOL, 3'($urandom_range(0, 3))), 1'b1);
		pause_until_drained();
		test_random_traffic(40);
		pause_until_drained();
	endtask

	initial begin
		for (int i = 0; i < 16; i++) begin
			cur_m[i] = '0;
			opb_m[i] = '0;
		end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_setup_cmds();
		test_index_range();
		test_arith_cmds();
		pause_until_drained();
		test_backpressure();
		test_random_traffic(1000);
		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
